// ===== sv/stli_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stli_pkg
// shared action and status codes, the interpolator sequencer states and the divider request and answer types
// ----------------------------------------------------------------------------
package stli_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,      // walk the table, issuing one entry read
    S_SCAN_WAIT, // memory read latency
    S_SHIFT,     // move entries up by one, top down
    S_SHIFT_WR,
    S_HI_RD,     // fetch upper breakpoint of a query; never entered by the sequencer
    S_HI_WAIT,
    S_MUL,
    S_DIV,
    S_FIN,
    S_OUT
  } state_t;

  // request to the divider
  typedef struct packed {
    logic               start;
    logic signed [32:0] num;
    logic        [16:0] den;
  } div_req_t;

  // answer from the divider
  typedef struct packed {
    logic               done;
    logic signed [32:0] quo;
  } div_rsp_t;

endpackage

// ===== sv/stli_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stli_div
// signed restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module stli_div (
  input  logic              clk,
  input  logic              rst,
  input  stli_pkg::div_req_t req,
  output stli_pkg::div_rsp_t rsp
);
  import stli_pkg::*;

  logic [32:0] quo;
  logic [17:0] rem;
  logic [16:0] den;
  logic [5:0]  cnt;
  logic        busy;
  logic        neg;
  logic        done;
  logic [17:0] trial;

  assign trial = {rem[16:0], quo[32]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd33;
        neg  <= req.num[32];
        quo  <= req.num[32] ? 33'(-req.num) : req.num;
        den  <= req.den;
        rem  <= '0;
      end else if (busy) begin
        if (!trial[17]) begin
          rem <= trial;
          quo <= {quo[31:0], 1'b1};
        end else begin
          rem <= {rem[16:0], quo[32]};
          quo <= {quo[31:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, (neg ? 33'(-quo) : quo)};

endmodule

// ===== sv/stli_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stli_mem
// breakpoint store: one write port, one registered read port, x and y paired
// ----------------------------------------------------------------------------
module stli_mem #(
  parameter int AW = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [31:0]       wdata,
  input  logic [AW-1:0]     raddr,
  output logic [31:0]       rdata
);
  logic [31:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/sorted_table_linear_interpolator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator_top
// piecewise linear interpolation over a sorted breakpoint table
// ----------------------------------------------------------------------------
// The table holds up to TABLE_DEPTH (x, y) points in ascending x in one
// single-port-read memory. Each transaction gives exactly one result. A load
// scans from entry 0, one entry read at a time, to the insert position and,
// for a new x, moves each entry from the top down to the insert slot up one
// place. A query scans to the bracketing pair, then a 33-step serial divider
// forms the slope term. Clear and the unused action code go straight from the
// accept to the output state. s_tready stays low until the result has been
// taken. No clearing pass is needed after reset.
module sorted_table_linear_interpolator_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // action[1:0], x_value[17:2], y_value[33:18]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // y_result[15:0], status[17:16], point_count[24:18]
);
  import stli_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t state, state_next;

  // held transaction
  logic [1:0]         act;
  logic signed [15:0] xin, yin;
  logic [CW-1:0]      count;     // entries held
  logic [CW-1:0]      pos;       // scan / shift index
  logic [CW-1:0]      ins;       // insert slot found by the scan
  logic               at_ins;
  logic signed [15:0] x0, y0;
  logic signed [16:0] dx;        // x1 - x0
  logic signed [32:0] prod;
  logic signed [15:0] yres;
  status_t            stat;

  // memory
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  logic signed [15:0] rx, ry;
  assign rx = rdata[15:0];
  assign ry = rdata[31:16];

  stli_mem #(.AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  div_req_t dreq;
  div_rsp_t drsp;
  stli_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign s_tready = (state == S_IDLE) && !m_tvalid;

  // when shifting reaches the insert slot the new point goes there
  assign at_ins = (pos == ins);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid && s_tready) begin
        if (s_tdata[1:0] == ACT_LOAD || s_tdata[1:0] == ACT_QUERY) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_OUT;
        end
      end
      S_SCAN: state_next = (pos < count) ? S_SCAN_WAIT : S_FIN;
      S_SCAN_WAIT: begin
        if (act == ACT_LOAD) begin
          if (rx < xin) state_next = S_SCAN;
          else state_next = (rx == xin) ? S_FIN : S_SHIFT;
        end else begin
          if (pos == '0 && xin < rx) state_next = S_FIN;
          else if (rx == xin) state_next = S_FIN;
          else if (rx < xin) state_next = S_SCAN;
          else state_next = S_MUL;
        end
      end
      S_SHIFT:    state_next = S_SHIFT_WR;
      S_SHIFT_WR: state_next = (at_ins || count == CW'(TABLE_DEPTH)) ? S_FIN : S_SHIFT;
      S_MUL:      state_next = S_DIV;
      S_DIV:      if (drsp.done) state_next = S_FIN;
      S_FIN:      state_next = S_OUT;
      S_OUT:      state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // memory and divider controls
  always_comb begin
    we    = 1'b0;
    waddr = pos[AW-1:0];
    wdata = {yin, xin};
    raddr = pos[AW-1:0];
    dreq.start = (state == S_MUL);
    dreq.num   = prod;
    dreq.den   = dx[16:0];
    case (state)
      // new x above every entry: append at the end
      S_SCAN: if (act == ACT_LOAD && pos >= count && count != CW'(TABLE_DEPTH)) we = 1'b1;
      S_SCAN_WAIT: if (act == ACT_LOAD && rx == xin) we = 1'b1;
      S_SHIFT:     raddr = AW'(pos - CW'(1));
      S_SHIFT_WR: begin
        we = (count != CW'(TABLE_DEPTH));
        if (at_ins) begin
          wdata = {yin, xin};
        end else begin
          wdata = rdata;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          act  <= s_tdata[1:0];
          xin  <= s_tdata[17:2];
          yin  <= s_tdata[33:18];
          pos  <= '0;
          yres <= '0;
          stat <= ST_OK;
          if (s_tdata[1:0] == ACT_CLEAR) count <= '0;
        end
        S_SCAN: if (pos >= count) begin
          if (act == ACT_QUERY) begin
            stat <= (count == '0) ? ST_EMPTY : ST_RANGE;
          end else if (count == CW'(TABLE_DEPTH)) begin
            stat <= ST_FULL;
          end else begin
            // append at the end
            count <= count + CW'(1);
          end
        end
        S_SCAN_WAIT: begin
          if (act == ACT_LOAD) begin
            if (rx < xin) pos <= pos + CW'(1);
            else if (rx != xin) begin
              // insert at pos: shift from top
              if (count == CW'(TABLE_DEPTH)) stat <= ST_FULL;
              else pos <= count;
            end
          end else begin
            if (pos == '0 && xin < rx) stat <= ST_RANGE;
            else if (rx == xin) yres <= ry;
            else if (rx < xin) begin
              x0  <= rx;
              y0  <= ry;
              pos <= pos + CW'(1);
            end else begin
              dx <= 17'(rx) - 17'(x0);
              prod <= (33'(xin) - 33'(x0)) * (33'(ry) - 33'(y0));
            end
          end
        end
        S_SHIFT_WR: if (count != CW'(TABLE_DEPTH)) begin
          if (at_ins) count <= count + CW'(1);
          else pos <= pos - CW'(1);
        end
        S_DIV: if (drsp.done) yres <= 16'(33'(y0) + drsp.quo);
        S_FIN: ;
        S_OUT: m_tvalid <= 1'b1;
        default: ;
      endcase
    end
  end

  // remember where the scan stopped for a load
  always_ff @(posedge clk) begin
    if (state == S_SCAN_WAIT && act == ACT_LOAD && !(rx < xin)) ins <= pos;
  end

  assign m_tdata = {7'd0, 7'(count), stat, yres};

  a_out_after_in: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_OUT) else $error("result without item");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH)) else $error("count overflow");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !s_tready) else $error("accept while busy");
endmodule
